>>> design/lpr_pkg.sv
// ---------------------------------------------------------------------------
// lpr_pkg: shared constants and types for the LRU page replacement block
// Sizes of the frame table, counters and the configuration register, and
// the result word passed from the replacement core to the output register.
// ---------------------------------------------------------------------------
package lpr_pkg;

  localparam int FRAMES    = 16;
  localparam int PAGE_BITS = 20;
  localparam int FILL_BITS = $clog2(FRAMES + 1);
  localparam int RANK_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_BITS  = 32;
  localparam int CFG_BITS  = 5;
  localparam int SZ_BITS   = (FILL_BITS > CFG_BITS) ? FILL_BITS : CFG_BITS;

  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(16);
  localparam logic [CNT_BITS-1:0] CNT_MAX   = '1;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [RANK_BITS-1:0] rank_t;
  typedef logic [FILL_BITS-1:0] fill_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef struct packed {
    logic  hit;
    logic  evicted_valid;
    page_t evicted_page;
    cnt_t  request_count;
    cnt_t  miss_count;
  } lpr_result_t;

endpackage

>>> design/lpr_in_reg.sv
// ---------------------------------------------------------------------------
// lpr_in_reg: request input register
// Holds one request word; frees up whenever the core consumes it, so a new
// word can be taken in the same cycle.
// ---------------------------------------------------------------------------
module lpr_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lpr_pkg::page_t in_page_number,
  input  logic           consume,
  output logic           req_valid,
  output lpr_pkg::page_t req_page
);
  import lpr_pkg::*;

  logic  valid_r, valid_nxt;
  page_t page_r;
  logic  accept;

  assign in_stall  = valid_r && !consume;
  assign accept    = in_valid && !in_stall;
  assign req_valid = valid_r;
  assign req_page  = page_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (consume) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page_r <= in_page_number;
    end
  end

endmodule

>>> design/lpr_core.sv
// ---------------------------------------------------------------------------
// lpr_core: frame table, recency ranks and counters
// Parallel compare of the request against all occupied frames, rank update
// and victim pick all take place in the same cycle. Rank 0 is least recent.
// ---------------------------------------------------------------------------
module lpr_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [lpr_pkg::CFG_BITS-1:0]  cfg_table_size,
  input  logic                          step_en,
  input  lpr_pkg::page_t                page,
  output lpr_pkg::lpr_result_t          res
);
  import lpr_pkg::*;

  logic [CFG_BITS-1:0] size_r;
  page_t               pages_r [FRAMES];
  rank_t               ranks_r [FRAMES];
  page_t               pages_nxt [FRAMES];
  rank_t               ranks_nxt [FRAMES];
  fill_t               fill_r, fill_nxt;
  cnt_t                req_r, req_nxt;
  cnt_t                miss_r, miss_nxt;

  logic [FRAMES-1:0]   occ, match, vic, target;
  logic [SZ_BITS-1:0]  eff_size, size_ext;
  rank_t               old_rank, pivot, top_rank;
  page_t               ev_page;
  logic                hit, full, append, evict;

  // clamp the frame count to 1..FRAMES
  always_comb begin
    size_ext = SZ_BITS'(size_r);
    if (size_ext == '0) begin
      eff_size = SZ_BITS'(1);
    end else if (size_ext > SZ_BITS'(FRAMES)) begin
      eff_size = SZ_BITS'(FRAMES);
    end else begin
      eff_size = size_ext;
    end
  end

  always_comb begin
    old_rank = '0;
    ev_page  = '0;
    for (int i = 0; i < FRAMES; i++) begin
      occ[i]   = fill_t'(i) < fill_r;
      match[i] = occ[i] && (pages_r[i] == page);
      vic[i]   = occ[i] && (ranks_r[i] == '0);
      if (match[i]) old_rank = old_rank | ranks_r[i];
      if (vic[i])   ev_page  = ev_page | pages_r[i];
    end
    hit      = |match;
    full     = SZ_BITS'(fill_r) >= eff_size;
    append   = !hit && !full;
    evict    = !hit && full;
    target   = hit ? match : vic;
    pivot    = hit ? old_rank : '0;
    top_rank = rank_t'(fill_r - fill_t'(1));
  end

  always_comb begin
    fill_nxt = fill_r;
    req_nxt  = req_r;
    miss_nxt = miss_r;
    for (int i = 0; i < FRAMES; i++) begin
      pages_nxt[i] = pages_r[i];
      ranks_nxt[i] = ranks_r[i];
    end
    if (step_en) begin
      req_nxt = (req_r == CNT_MAX) ? req_r : req_r + cnt_t'(1);
      if (!hit) begin
        miss_nxt = (miss_r == CNT_MAX) ? miss_r : miss_r + cnt_t'(1);
      end
      if (append) begin
        fill_nxt = fill_r + fill_t'(1);
        for (int i = 0; i < FRAMES; i++) begin
          if (fill_t'(i) == fill_r) begin
            pages_nxt[i] = page;
            ranks_nxt[i] = rank_t'(fill_r);
          end
        end
      end else begin
        // move the touched frame to most recent, close the gap below it
        for (int i = 0; i < FRAMES; i++) begin
          if (target[i]) begin
            ranks_nxt[i] = top_rank;
            if (evict) pages_nxt[i] = page;
          end else if (occ[i] && ranks_r[i] > pivot) begin
            ranks_nxt[i] = ranks_r[i] - rank_t'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= CFG_RESET;
      fill_r <= '0;
      req_r  <= '0;
      miss_r <= '0;
    end else begin
      if (cfg_valid) size_r <= cfg_table_size;
      fill_r <= fill_nxt;
      req_r  <= req_nxt;
      miss_r <= miss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < FRAMES; i++) begin
      pages_r[i] <= pages_nxt[i];
      ranks_r[i] <= ranks_nxt[i];
    end
  end

  always_comb begin
    res.hit           = hit;
    res.evicted_valid = evict;
    res.evicted_page  = evict ? ev_page : '0;
    res.request_count = req_nxt;
    res.miss_count    = miss_nxt;
  end

endmodule

>>> design/lpr_out_reg.sv
// ---------------------------------------------------------------------------
// lpr_out_reg: result output register
// Holds one result word until the receiver takes it.
// ---------------------------------------------------------------------------
module lpr_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  lpr_pkg::lpr_result_t res,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 free,
  output lpr_pkg::lpr_result_t res_q
);
  import lpr_pkg::*;

  logic        valid_r, valid_nxt;
  lpr_result_t res_r;

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign res_q     = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

>>> design/lru_page_replacement.sv
// An accepted request word is held in the input register, and its result
// word in the output register. Throughput: one request per cycle unless
// out_stall holds the output; compare and rank update are combinational.
// A zero page number is consumed without producing a result.
// Reset (synchronous, rst_n low): no pages resident, counters zero,
// table_size 16; both word registers empty.
// ---------------------------------------------------------------------------
// lru_page_replacement: LRU page replacement unit
// Fills frames up to table_size (clamped to 1..FRAMES), reports hits and
// evictions and keeps saturating request and miss counts.
// ---------------------------------------------------------------------------
module lru_page_replacement (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lpr_pkg::page_t                in_page_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_hit,
  output logic                          out_evicted_valid,
  output lpr_pkg::page_t                out_evicted_page,
  output lpr_pkg::cnt_t                 out_request_count,
  output lpr_pkg::cnt_t                 out_miss_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lpr_pkg::CFG_BITS-1:0]  cfg_table_size
);
  import lpr_pkg::*;

  logic        req_valid, free, consume, step_en;
  page_t       req_page;
  lpr_result_t res, res_q;

  assign cfg_ready = 1'b1;
  assign consume   = req_valid && free;
  // drop empty requests without a result
  assign step_en   = consume && (req_page != '0);

  lpr_in_reg u_in (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_page_number (in_page_number),
    .consume        (consume),
    .req_valid      (req_valid),
    .req_page       (req_page)
  );

  lpr_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_table_size (cfg_table_size),
    .step_en        (step_en),
    .page           (req_page),
    .res            (res)
  );

  lpr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_en),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (free),
    .res_q     (res_q)
  );

  assign out_hit           = res_q.hit;
  assign out_evicted_valid = res_q.evicted_valid;
  assign out_evicted_page  = res_q.evicted_page;
  assign out_request_count = res_q.request_count;
  assign out_miss_count    = res_q.miss_count;

endmodule

>>> design/lpr_checker.sv
// ---------------------------------------------------------------------------
// lpr_checker: port-level checks for the LRU page replacement unit
// Watches the result channel for consistency of the reported fields.
// ---------------------------------------------------------------------------
module lpr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_hit,
  input logic                          out_evicted_valid,
  input lpr_pkg::page_t                out_evicted_page,
  input lpr_pkg::cnt_t                 out_request_count,
  input lpr_pkg::cnt_t                 out_miss_count
);
  import lpr_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_request_count)
      && $stable(out_evicted_page))
    else $error("result word changed while stalled");

  a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> out_evicted_page == '0)
    else $error("evicted page nonzero without eviction");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted_valid))
    else $error("hit reported together with eviction");

  a_miss_le_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_miss_count <= out_request_count)
    else $error("miss count exceeds request count");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (.*);

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for lru_page_replacement
// Sends page requests and table_size writes, keeps an LRU frame table of its
// own to predict hit, eviction and counter values, and compares every result
// word against that prediction under several idle and stall mixes.
// ---------------------------------------------------------------------------
module tb;
  import lpr_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  page_t               in_page_number = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                out_hit;
  logic                out_evicted_valid;
  page_t               out_evicted_page;
  cnt_t                out_request_count;
  cnt_t                out_miss_count;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_table_size = '0;

  int gap_pct = 0;
  int stall_pct = 0;
  int errors = 0;

  // LRU frame table tracked alongside the block
  logic [CFG_BITS-1:0] size_reg = CFG_RESET;
  page_t               resident [FRAMES];
  rank_t               age_rank [FRAMES];
  fill_t               occupied = '0;
  cnt_t                req_total = '0;
  cnt_t                miss_total = '0;
  lpr_result_t         outcome_q [$];

  lru_page_replacement u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_request_count (out_request_count),
    .out_miss_count    (out_miss_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_table_size    (cfg_table_size)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int frames_in_use();
    if (size_reg == '0) return 1;
    if (int'(size_reg) > FRAMES) return FRAMES;
    return int'(size_reg);
  endfunction

  // Make frame f most recent; younger ranks shift down by one.
  function automatic void promote(int f);
    rank_t old_rank;
    old_rank = age_rank[f];
    for (int i = 0; i < int'(occupied); i++)
      if (age_rank[i] > old_rank) age_rank[i] = age_rank[i] - rank_t'(1);
    age_rank[f] = rank_t'(occupied - fill_t'(1));
  endfunction

  function automatic void lru_access(page_t pg);
    lpr_result_t r;
    int          where;
    int          victim;
    where = -1;
    victim = -1;
    if (pg == '0) return;
    r = '0;
    if (req_total != CNT_MAX) req_total = req_total + cnt_t'(1);
    for (int i = 0; i < int'(occupied); i++)
      if (where < 0 && resident[i] == pg) where = i;
    if (where >= 0) begin
      r.hit = 1'b1;
      promote(where);
    end else begin
      if (miss_total != CNT_MAX) miss_total = miss_total + cnt_t'(1);
      if (int'(occupied) < frames_in_use()) begin
        resident[occupied] = pg;
        age_rank[occupied] = rank_t'(occupied);
        occupied = occupied + fill_t'(1);
      end else begin
        for (int i = 0; i < int'(occupied); i++)
          if (victim < 0 && age_rank[i] == '0) victim = i;
        r.evicted_valid = 1'b1;
        r.evicted_page = resident[victim];
        resident[victim] = pg;
        promote(victim);
      end
    end
    r.request_count = req_total;
    r.miss_count = miss_total;
    outcome_q.push_back(r);
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
    end
  endfunction

  // Result side: check each accepted word, then pick the next stall.
  always @(posedge clk) begin
    lpr_result_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected", $time);
      end else begin
        want = outcome_q.pop_front();
        check_field("hit", 32'(want.hit), 32'(out_hit));
        check_field("evicted_valid", 32'(want.evicted_valid), 32'(out_evicted_valid));
        check_field("evicted_page", 32'(want.evicted_page), 32'(out_evicted_page));
        check_field("request_count", want.request_count, out_request_count);
        check_field("miss_count", want.miss_count, out_miss_count);
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Send one request word and hold it until accepted.
  task automatic send_page(page_t pg);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_page_number <= pg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lru_access(pg);
  endtask

  // Drop valid and wait until every predicted word has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_BITS-1:0] sz);
    drain();
    cfg_valid <= 1'b1;
    cfg_table_size <= sz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    size_reg = sz;
  endtask

  task automatic test_request_basics();
    send_page(20'h00001);
    send_page(20'hFFFFF);
    send_page(20'h00000);
    send_page(20'h00001);
    send_page(20'hAAAAA);
    send_page(20'h55555);
    send_page(20'hFFFFF);
  endtask

  // Size 0 acts as 1 (and lands below the current fill), sizes above 16 clamp.
  task automatic test_size_clamp();
    set_size(5'd0);
    send_page(20'h00007);
    send_page(20'h00007);
    send_page(20'h00008);
    set_size(5'd31);
    send_page(20'h00009);
    send_page(20'h0000A);
    set_size(5'd17);
    send_page(20'h0000B);
  endtask

  task automatic test_shrink_below_fill();
    set_size(5'd2);
    send_page(20'h00100);
    send_page(20'h00200);
    send_page(20'h00009);
    send_page(20'h00200);
    set_size(5'd16);
    send_page(20'h00300);
  endtask

  // Mostly a small working set of random pages so hits and evictions mix.
  task automatic test_random_traffic(int n_req, logic [CFG_BITS-1:0] sz, int gap, int stall);
    page_t pool [24];
    int    span;
    int    sent;
    int    pick;
    page_t pg;
    set_size(sz);
    gap_pct = gap;
    stall_pct = stall;
    span = $urandom_range(23) + 1;
    sent = 0;
    foreach (pool[i]) begin
      pool[i] = page_t'($urandom);
      if (pool[i] == '0) pool[i] = page_t'(i + 1);
    end
    while (sent < n_req) begin
      pick = $urandom_range(99);
      if (pick < 5) pg = '0;
      else if (pick < 15) pg = page_t'($urandom);
      else pg = pool[$urandom_range(span - 1)];
      send_page(pg);
      if (pg != '0) sent++;
    end
  endtask

  initial begin
    logic [CFG_BITS-1:0] sizes [8];
    int gaps [4];
    int stalls [4];
    sizes = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd17, 5'd3, 5'd9};
    sizes[7] = CFG_BITS'($urandom_range(31));
    gaps = '{0, 50, 0, 26};
    stalls = '{0, 0, 50, 26};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_request_basics();
    test_size_clamp();
    test_shrink_below_fill();
    for (int p = 0; p < 8; p++)
      test_random_traffic(230, sizes[p], gaps[p % 4], stalls[p % 4]);
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
